>>> src/fci_pkg.sv
package fci_pkg;

    localparam int FRAME_WIDTH_DEF    = 320;
    localparam int FRAME_HEIGHT_DEF   = 240;
    localparam int FLOW_FRAC_BITS_DEF = 4;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_OUTPUT     = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_t;

    localparam logic REG_BLEND_POSITION = 1'b0;
    localparam logic REG_FORWARD_ONLY   = 1'b1;

    typedef struct packed {
        logic [16:0] w00;
        logic [16:0] w10;
        logic [16:0] w01;
        logic [16:0] w11;
    } weights_t;

    typedef struct packed {
        logic [23:0] c00;
        logic [23:0] c10;
        logic [23:0] c01;
        logic [23:0] c11;
    } corners_t;

endpackage

>>> src/fci_source_pos.sv
module fci_source_pos #(
    parameter int SIZE = fci_pkg::FRAME_WIDTH_DEF,
    parameter int FRAC = fci_pkg::FLOW_FRAC_BITS_DEF,
    parameter int PW   = $clog2(SIZE) + 8
) (
    input  logic                clk,
    input  logic                en,
    input  logic [8:0]          coord,
    input  logic [8:0]          weight,
    input  logic signed [15:0]  flow,
    output logic [PW-1:0]       pos
);

    localparam int HI = (SIZE - 1) * 256 - 1;

    logic signed [25:0] prod_reg;
    logic signed [25:0] prod_next;
    logic [8:0]         coord_reg;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic signed [27:0] prod_ext;
    logic signed [27:0] shifted;
    logic signed [27:0] p;

    always_comb
    begin
        prod_next = $signed({1'b0, weight}) * flow;
        prod_ext  = 28'(prod_reg);
        shifted   = prod_ext >>> FRAC;
        p         = $signed({11'b0, coord_reg, 8'b0}) - shifted;
        if (p < 28'sd0)
        begin
            pos_next = '0;
        end
        else if (p > $signed(28'(HI)))
        begin
            pos_next = PW'(HI);
        end
        else
        begin
            pos_next = PW'(p);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            coord_reg <= coord;
            pos_reg   <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

>>> src/fci_frame_store.sv
module fci_frame_store #(
    parameter int W   = fci_pkg::FRAME_WIDTH_DEF,
    parameter int H   = fci_pkg::FRAME_HEIGHT_DEF,
    parameter int XW  = $clog2(W),
    parameter int YW  = $clog2(H)
) (
    input  logic                clk,
    input  logic                en,
    input  logic                wr,
    input  logic [XW-1:0]       wx,
    input  logic [YW-1:0]       wy,
    input  logic [23:0]         wdata,
    input  logic [XW+7:0]       px,
    input  logic [YW+7:0]       py,
    output fci_pkg::corners_t   corners,
    output fci_pkg::weights_t   weights
);

    localparam int HW    = (W + 1) / 2;
    localparam int HH    = (H + 1) / 2;
    localparam int DEPTH = HW * HH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0]     waddr;
    logic [1:0]        wbank;
    logic [XW-1:0]     ix;
    logic [YW-1:0]     iy;
    logic [7:0]        fx;
    logic [7:0]        fy;
    logic [AW-1:0]     raddr [4];
    logic [23:0]       rdata_reg [4];
    logic              ix0_reg;
    logic              iy0_reg;
    fci_pkg::weights_t weights_reg;
    fci_pkg::weights_t weights_next;

    always_comb
    begin
        waddr = AW'(AW'(wy >> 1) * AW'(HW) + AW'(wx >> 1));
        wbank = {wy[0], wx[0]};
        ix    = px[XW+7:8];
        iy    = py[YW+7:8];
        fx    = px[7:0];
        fy    = py[7:0];
        weights_next.w00 = 17'((9'd256 - {1'b0, fx}) * (9'd256 - {1'b0, fy}));
        weights_next.w10 = 17'({1'b0, fx} * (9'd256 - {1'b0, fy}));
        weights_next.w01 = 17'((9'd256 - {1'b0, fx}) * {1'b0, fy});
        weights_next.w11 = 17'({1'b0, fx} * {1'b0, fy});
    end

    // Four banks split by row and column parity so that all four corners of a
    // bilinear footprint are read in the same cycle.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [23:0]   mem [DEPTH];
        logic [XW-1:0] cx;
        logic [YW-1:0] cy;

        always_comb
        begin
            cx = (ix[0] == b[0]) ? ix : XW'(ix + 1'b1);
            cy = (iy[0] == b[1]) ? iy : YW'(iy + 1'b1);
            raddr[b] = AW'(AW'(cy >> 1) * AW'(HW) + AW'(cx >> 1));
        end

        always_ff @(posedge clk)
        begin
            if (en && wr && (wbank == 2'(b)))
            begin
                mem[waddr] <= wdata;
            end
            if (en)
            begin
                rdata_reg[b] <= mem[raddr[b]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix0_reg     <= ix[0];
            iy0_reg     <= iy[0];
            weights_reg <= weights_next;
        end
    end

    assign corners.c00 = rdata_reg[{iy0_reg, ix0_reg}];
    assign corners.c10 = rdata_reg[{iy0_reg, ~ix0_reg}];
    assign corners.c01 = rdata_reg[{~iy0_reg, ix0_reg}];
    assign corners.c11 = rdata_reg[{~iy0_reg, ~ix0_reg}];
    assign weights     = weights_reg;

endmodule

>>> src/fci_bilinear.sv
module fci_bilinear (
    input  logic              clk,
    input  logic              en,
    input  fci_pkg::corners_t corners,
    input  fci_pkg::weights_t weights,
    output logic [23:0]       rgb
);

    logic [23:0] rgb_reg;
    logic [23:0] rgb_next;
    logic [25:0] acc [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = 26'(weights.w00 * corners.c00[16-8*k +: 8])
                   + 26'(weights.w10 * corners.c10[16-8*k +: 8])
                   + 26'(weights.w01 * corners.c01[16-8*k +: 8])
                   + 26'(weights.w11 * corners.c11[16-8*k +: 8]);
            rgb_next[16-8*k +: 8] = acc[k][23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

>>> src/flow_compensated_frame_interpolator.sv
// An output request reaches the master side through the valid pipeline stages and the output register.
// Throughput: one item per cycle while the output is not stalled; the four parity banks of each frame store
// serve all eight corner reads of an output pixel in the same cycle.
// Loads are written in the same pipeline stage as the reads, so items keep their order.
// Reset clears the pipeline valid bits and the registers (position 128, blending on);
// frame memory contents are not cleared.
module flow_compensated_frame_interpolator #(
    parameter int FRAME_WIDTH    = fci_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT   = fci_pkg::FRAME_HEIGHT_DEF,
    parameter int FLOW_FRAC_BITS = fci_pkg::FLOW_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd, pixel_x, pixel_y, red, green, blue, fwd_dx, fwd_dy, bwd_dx, bwd_dy
    input  logic [fci_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_x, out_y, out_red, out_green, out_blue
    output logic [fci_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [8:0]                      cfg_data
);

    localparam int XW = $clog2(FRAME_WIDTH);
    localparam int YW = $clog2(FRAME_HEIGHT);

    logic              en;
    logic              accept;
    fci_pkg::cmd_t     cmd;
    logic [8:0]        pix_x;
    logic [7:0]        pix_y;
    logic [8:0]        pc;
    logic [8:0]        lw;

    logic [8:0]        blend_position_reg;
    logic              forward_only_reg;

    logic [3:0]        valid_reg;
    logic [3:0]        valid_next;
    logic              out_valid_reg;
    fci_pkg::cmd_t     cmd1_reg, cmd2_reg;
    logic              inside1_reg, inside2_reg;
    logic [8:0]        x1_reg, x2_reg, x3_reg, x4_reg, xo_reg;
    logic [7:0]        y1_reg, y2_reg, y3_reg, y4_reg, yo_reg;
    logic [23:0]       d1_reg, d2_reg;
    logic              emit3_reg, emit4_reg;
    logic [23:0]       rgb_out_reg;
    logic [23:0]       rgb_out_next;

    logic [XW+7:0]     lpx, rpx;
    logic [YW+7:0]     lpy, rpy;
    fci_pkg::corners_t lcorners, rcorners;
    fci_pkg::weights_t lweights, rweights;
    logic [23:0]       lrgb, rrgb;
    logic              wr_left, wr_right;
    logic [16:0]       mix;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign cmd           = fci_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign pix_x         = s_axis_tdata[10:2];
    assign pix_y         = s_axis_tdata[18:11];
    assign pc            = (blend_position_reg > 9'd256) ? 9'd256 : blend_position_reg;
    assign lw            = 9'd256 - pc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_position_reg <= 9'd128;
            forward_only_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fci_pkg::REG_BLEND_POSITION: blend_position_reg <= cfg_data;
                fci_pkg::REG_FORWARD_ONLY:   forward_only_reg   <= cfg_data[0];
                default:                     blend_position_reg <= blend_position_reg;
            endcase
        end
    end

    fci_source_pos #(.SIZE(FRAME_WIDTH), .FRAC(FLOW_FRAC_BITS), .PW(XW + 8)) u_lpx (
        .clk(clk), .en(en), .coord(pix_x), .weight(pc),
        .flow($signed(s_axis_tdata[58:43])), .pos(lpx));
    fci_source_pos #(.SIZE(FRAME_HEIGHT), .FRAC(FLOW_FRAC_BITS), .PW(YW + 8)) u_lpy (
        .clk(clk), .en(en), .coord({1'b0, pix_y}), .weight(pc),
        .flow($signed(s_axis_tdata[74:59])), .pos(lpy));
    fci_source_pos #(.SIZE(FRAME_WIDTH), .FRAC(FLOW_FRAC_BITS), .PW(XW + 8)) u_rpx (
        .clk(clk), .en(en), .coord(pix_x), .weight(lw),
        .flow($signed(s_axis_tdata[90:75])), .pos(rpx));
    fci_source_pos #(.SIZE(FRAME_HEIGHT), .FRAC(FLOW_FRAC_BITS), .PW(YW + 8)) u_rpy (
        .clk(clk), .en(en), .coord({1'b0, pix_y}), .weight(lw),
        .flow($signed(s_axis_tdata[106:91])), .pos(rpy));

    assign wr_left  = valid_reg[1] && inside2_reg && (cmd2_reg == fci_pkg::CMD_LOAD_LEFT);
    assign wr_right = valid_reg[1] && inside2_reg && (cmd2_reg == fci_pkg::CMD_LOAD_RIGHT);

    fci_frame_store #(.W(FRAME_WIDTH), .H(FRAME_HEIGHT), .XW(XW), .YW(YW)) u_left (
        .clk(clk), .en(en), .wr(wr_left), .wx(XW'(x2_reg)), .wy(YW'(y2_reg)),
        .wdata(d2_reg), .px(lpx), .py(lpy), .corners(lcorners), .weights(lweights));
    fci_frame_store #(.W(FRAME_WIDTH), .H(FRAME_HEIGHT), .XW(XW), .YW(YW)) u_right (
        .clk(clk), .en(en), .wr(wr_right), .wx(XW'(x2_reg)), .wy(YW'(y2_reg)),
        .wdata(d2_reg), .px(rpx), .py(rpy), .corners(rcorners), .weights(rweights));

    fci_bilinear u_lbil (.clk(clk), .en(en), .corners(lcorners), .weights(lweights),
        .rgb(lrgb));
    fci_bilinear u_rbil (.clk(clk), .en(en), .corners(rcorners), .weights(rweights),
        .rgb(rrgb));

    always_comb
    begin
        valid_next = {valid_reg[2:0], accept};
        mix        = '0;
        for (int k = 0; k < 3; k++)
        begin
            mix = 17'(lw * lrgb[8*k +: 8]) + 17'(pc * rrgb[8*k +: 8]);
            if (forward_only_reg)
            begin
                rgb_out_next[8*k +: 8] = lrgb[8*k +: 8];
            end
            else if (mix[16])
            begin
                rgb_out_next[8*k +: 8] = 8'd255;
            end
            else
            begin
                rgb_out_next[8*k +: 8] = mix[15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[3] && emit4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg    <= cmd;
            inside1_reg <= (32'(pix_x) < FRAME_WIDTH) && (32'(pix_y) < FRAME_HEIGHT);
            x1_reg      <= pix_x;
            y1_reg      <= pix_y;
            d1_reg      <= {s_axis_tdata[26:19], s_axis_tdata[34:27], s_axis_tdata[42:35]};
            cmd2_reg    <= cmd1_reg;
            inside2_reg <= inside1_reg;
            x2_reg      <= x1_reg;
            y2_reg      <= y1_reg;
            d2_reg      <= d1_reg;
            emit3_reg   <= (cmd2_reg == fci_pkg::CMD_OUTPUT);
            x3_reg      <= x2_reg;
            y3_reg      <= y2_reg;
            emit4_reg   <= emit3_reg;
            x4_reg      <= x3_reg;
            y4_reg      <= y3_reg;
            xo_reg      <= x4_reg;
            yo_reg      <= y4_reg;
            rgb_out_reg <= rgb_out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, rgb_out_reg[7:0], rgb_out_reg[15:8], rgb_out_reg[23:16],
                            yo_reg, xo_reg};

endmodule
